[hw/rtl/abp_pkg.sv]
package abp_pkg;

    // Configuration port geometry
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 26;

    // Register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        REG_COEF_A = 3'd0,
        REG_COEF_B = 3'd1,
        REG_COEF_C = 3'd2,
        REG_COEF_D = 3'd3,
        REG_CENTER = 3'd4,
        REG_SCROLL = 3'd5,
        REG_MODE   = 3'd6,
        REG_PRIO   = 3'd7
    } cfg_reg_t;

    // Request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Bit positions inside mode_flags
    localparam int MODE_WRAP = 0;
    localparam int MODE_FILL = 1;
    localparam int MODE_EXT  = 2;
    localparam int MODE_MATH = 3;

    // Configuration registers as seen by the pipeline
    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
        logic signed [15:0] coef_d;
        logic [25:0]        center_xy;
        logic [25:0]        scroll_xy;
        logic [3:0]         mode_flags;
        logic [15:0]        priorities;
    } cfg_t;

    // Item leaving the coordinate stages
    typedef struct packed {
        logic        req_type;
        logic [14:0] mem_addr;
        logic [15:0] mem_data;
        logic [7:0]  dst_x;
        logic [9:0]  src_x;
        logic [9:0]  src_y;
        logic        in_range;
    } coord_t;

endpackage

[hw/rtl/abp_in_if.sv]
interface abp_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [14:0] mem_addr;
    logic [15:0] mem_data;
    logic [7:0]  line;
    logic [7:0]  dst_x;

    modport source (
        output valid,
        output req_type,
        output mem_addr,
        output mem_data,
        output line,
        output dst_x,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  mem_addr,
        input  mem_data,
        input  line,
        input  dst_x,
        output ready
    );
endinterface

[hw/rtl/abp_out_if.sv]
interface abp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_x;
    logic [7:0] color_index;
    logic [7:0] priority_res;
    logic       color_math;

    modport source (
        output valid,
        output out_x,
        output color_index,
        output priority_res,
        output color_math,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_x,
        input  color_index,
        input  priority_res,
        input  color_math,
        output ready
    );
endinterface

[hw/rtl/abp_coord.sv]
module abp_coord
    import abp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    abp_in_if.sink req,
    output logic   crd_valid,
    input  logic   crd_ready,
    output coord_t crd
);

    typedef struct packed {
        logic        req_type;
        logic [14:0] mem_addr;
        logic [15:0] mem_data;
        logic [7:0]  dst_x;
    } pass_t;

    // Stage enables, collapsing bubbles
    logic ld1, ld2, ld3;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1: offsets and products
    logic signed [12:0] cen_x, cen_y, scr_x, scr_y;
    logic [13:0]        dif_x, dif_y;
    logic signed [10:0] off_x, off_y;
    logic signed [8:0]  line_s, dx_s;
    logic signed [26:0] p_aox_next, p_boy_next, p_cox_next, p_doy_next;
    logic signed [24:0] p_bl_next, p_adx_next, p_dl_next, p_cdx_next;
    pass_t              pass_next;

    logic signed [26:0] p_aox_reg, p_boy_reg, p_cox_reg, p_doy_reg;
    logic signed [24:0] p_bl_reg, p_adx_reg, p_dl_reg, p_cdx_reg;
    pass_t              pass1_reg;

    // Stage 2: partial sums
    logic [31:0] t0x_next, t1x_next, tdx_next, t0y_next, t1y_next, tdy_next;
    logic [31:0] t0x_reg, t1x_reg, tdx_reg, t0y_reg, t1y_reg, tdy_reg;
    pass_t       pass2_reg;

    // Stage 3: source coordinate
    logic [31:0] sum_x, sum_y;
    coord_t      crd_next;
    coord_t      crd_reg;

    assign ld3 = !v3_reg || crd_ready;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign req.ready = ld1;

    // Cut scroll minus centre to a signed 11-bit offset: sign bit and low ten bits
    always_comb
    begin
        cen_x  = cfg.center_xy[12:0];
        cen_y  = cfg.center_xy[25:13];
        scr_x  = cfg.scroll_xy[12:0];
        scr_y  = cfg.scroll_xy[25:13];
        dif_x  = {scr_x[12], scr_x} - {cen_x[12], cen_x};
        dif_y  = {scr_y[12], scr_y} - {cen_y[12], cen_y};
        off_x  = {dif_x[13], dif_x[9:0]};
        off_y  = {dif_y[13], dif_y[9:0]};
        line_s = $signed({1'b0, req.line});
        dx_s   = $signed({1'b0, req.dst_x});
    end

    // Form the eight matrix products
    always_comb
    begin
        p_aox_next = $signed(cfg.coef_a) * off_x;
        p_bl_next  = $signed(cfg.coef_b) * line_s;
        p_boy_next = $signed(cfg.coef_b) * off_y;
        p_adx_next = $signed(cfg.coef_a) * dx_s;
        p_cox_next = $signed(cfg.coef_c) * off_x;
        p_dl_next  = $signed(cfg.coef_d) * line_s;
        p_doy_next = $signed(cfg.coef_d) * off_y;
        p_cdx_next = $signed(cfg.coef_c) * dx_s;
        pass_next.req_type = req.req_type;
        pass_next.mem_addr = req.mem_addr;
        pass_next.mem_data = req.mem_data;
        pass_next.dst_x    = req.dst_x;
    end

    // Clear the low six bits of three products per axis and add the centre
    always_comb
    begin
        t0x_next = {{5{p_aox_reg[26]}}, p_aox_reg[26:6], 6'd0}
                 + {{7{p_bl_reg[24]}}, p_bl_reg[24:6], 6'd0};
        t1x_next = {{5{p_boy_reg[26]}}, p_boy_reg[26:6], 6'd0}
                 + {{11{cen_x[12]}}, cen_x, 8'd0};
        tdx_next = {{7{p_adx_reg[24]}}, p_adx_reg};
        t0y_next = {{5{p_cox_reg[26]}}, p_cox_reg[26:6], 6'd0}
                 + {{7{p_dl_reg[24]}}, p_dl_reg[24:6], 6'd0};
        t1y_next = {{5{p_doy_reg[26]}}, p_doy_reg[26:6], 6'd0}
                 + {{11{cen_y[12]}}, cen_y, 8'd0};
        tdy_next = {{7{p_cdx_reg[24]}}, p_cdx_reg};
    end

    // Final sum, integer part and map range check
    always_comb
    begin
        sum_x = t0x_reg + t1x_reg + tdx_reg;
        sum_y = t0y_reg + t1y_reg + tdy_reg;
        crd_next.req_type = pass2_reg.req_type;
        crd_next.mem_addr = pass2_reg.mem_addr;
        crd_next.mem_data = pass2_reg.mem_data;
        crd_next.dst_x    = pass2_reg.dst_x;
        crd_next.src_x    = sum_x[17:8];
        crd_next.src_y    = sum_y[17:8];
        crd_next.in_range = cfg.mode_flags[MODE_WRAP]
                          || ((sum_x[31:18] == 14'd0) && (sum_y[31:18] == 14'd0));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= req.valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            p_aox_reg <= p_aox_next;
            p_bl_reg  <= p_bl_next;
            p_boy_reg <= p_boy_next;
            p_adx_reg <= p_adx_next;
            p_cox_reg <= p_cox_next;
            p_dl_reg  <= p_dl_next;
            p_doy_reg <= p_doy_next;
            p_cdx_reg <= p_cdx_next;
            pass1_reg <= pass_next;
        end
        if (ld2)
        begin
            t0x_reg   <= t0x_next;
            t1x_reg   <= t1x_next;
            tdx_reg   <= tdx_next;
            t0y_reg   <= t0y_next;
            t1y_reg   <= t1y_next;
            tdy_reg   <= tdy_next;
            pass2_reg <= pass1_reg;
        end
        if (ld3)
        begin
            crd_reg <= crd_next;
        end
    end

    assign crd_valid = v3_reg;
    assign crd       = crd_reg;

endmodule

[hw/rtl/abp_fetch.sv]
module abp_fetch
    import abp_pkg::*;
#(
    parameter int MEM_WORDS = 32768
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       crd_valid,
    output logic       crd_ready,
    input  coord_t     crd,
    abp_out_if.source  pix
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [15:0] mem [MEM_WORDS];

    logic ld4, ld5, ld6;
    logic v4_reg, v5_reg, v6_reg;

    // Stage 4: map word
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] map_addr;
    logic [15:0]   map_rd_reg;
    logic [7:0]    dx4_reg;
    logic [2:0]    fx4_reg, fy4_reg;
    logic          inr4_reg;

    // Stage 5: character word
    logic [7:0]    tile;
    logic          have_next;
    logic [AW-1:0] chr_addr;
    logic [15:0]   chr_rd_reg;
    logic [7:0]    dx5_reg;
    logic          have5_reg;

    // Stage 6: output register
    logic [7:0] color_next, prio_next, pxl;
    logic [7:0] out_x_reg, color_reg, prio_reg;
    logic       math_reg;

    assign ld6 = !v6_reg || pix.ready;
    assign ld5 = !v5_reg || ld6;
    assign ld4 = !v4_reg || ld5;
    assign crd_ready = ld4;

    // Write at the map read stage: older items read old data, younger see the new word
    always_comb
    begin
        wr_en    = crd_valid && ld4 && (crd.req_type == REQ_WRITE)
                 && (32'(crd.mem_addr) < 32'(MEM_WORDS));
        wr_addr  = AW'(crd.mem_addr);
        map_addr = AW'({crd.src_y[9:3], crd.src_x[9:3]});
    end

    // Pick the tile, or tile 0 outside the map
    always_comb
    begin
        tile      = inr4_reg ? map_rd_reg[7:0] : 8'd0;
        have_next = inr4_reg || cfg.mode_flags[MODE_FILL];
        chr_addr  = AW'({tile, fy4_reg, fx4_reg});
    end

    // Pixel colour index and extended-layer priority
    always_comb
    begin
        pxl        = have5_reg ? chr_rd_reg[15:8] : 8'd0;
        prio_next  = cfg.priorities[7:0];
        color_next = pxl;
        if (have5_reg && cfg.mode_flags[MODE_EXT])
        begin
            if (pxl[7])
            begin
                prio_next = cfg.priorities[15:8];
            end
            color_next = {1'b0, pxl[6:0]};
        end
    end

    // Video memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= crd.mem_data;
        end
        if (ld4)
        begin
            map_rd_reg <= mem[map_addr];
        end
        if (ld5)
        begin
            chr_rd_reg <= mem[chr_addr];
        end
    end

    // Advance valid bits; drop memory writes after stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (ld4)
            begin
                v4_reg <= crd_valid && (crd.req_type == REQ_RENDER);
            end
            if (ld5)
            begin
                v5_reg <= v4_reg;
            end
            if (ld6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            dx4_reg  <= crd.dst_x;
            fx4_reg  <= crd.src_x[2:0];
            fy4_reg  <= crd.src_y[2:0];
            inr4_reg <= crd.in_range;
        end
        if (ld5)
        begin
            dx5_reg   <= dx4_reg;
            have5_reg <= have_next;
        end
        if (ld6)
        begin
            out_x_reg <= dx5_reg;
            color_reg <= color_next;
            prio_reg  <= prio_next;
            math_reg  <= cfg.mode_flags[MODE_MATH];
        end
    end

    assign pix.valid        = v6_reg;
    assign pix.out_x        = out_x_reg;
    assign pix.color_index  = color_reg;
    assign pix.priority_res = prio_reg;
    assign pix.color_math   = math_reg;

endmodule

[hw/rtl/affine_background_pixel_fetch.sv]
// A render result passes the registers of stages 1 to 6 in order, the last being the output
// register; its output transfer then waits for pix.ready.
// Throughput: one item per cycle while pix.ready is high; six register stages with a valid
// bit each absorb stalls. The rate is set by the two read ports of the video memory: map and
// character word per pixel. Reset clears the configuration registers and all valid bits;
// video memory has no reset and must be written before it is read.
module affine_background_pixel_fetch
    import abp_pkg::*;
#(
    parameter int MEM_WORDS = 32768
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    abp_in_if.sink              req,
    abp_out_if.source           pix
);

    cfg_t   cfg_reg;
    logic   crd_valid, crd_ready;
    coord_t crd;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COEF_A: cfg_reg.coef_a     <= cfg_data[15:0];
                REG_COEF_B: cfg_reg.coef_b     <= cfg_data[15:0];
                REG_COEF_C: cfg_reg.coef_c     <= cfg_data[15:0];
                REG_COEF_D: cfg_reg.coef_d     <= cfg_data[15:0];
                REG_CENTER: cfg_reg.center_xy  <= cfg_data[25:0];
                REG_SCROLL: cfg_reg.scroll_xy  <= cfg_data[25:0];
                REG_MODE:   cfg_reg.mode_flags <= cfg_data[3:0];
                REG_PRIO:   cfg_reg.priorities <= cfg_data[15:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    abp_coord u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .crd_valid (crd_valid),
        .crd_ready (crd_ready),
        .crd       (crd)
    );

    abp_fetch #(
        .MEM_WORDS (MEM_WORDS)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .crd_valid (crd_valid),
        .crd_ready (crd_ready),
        .crd       (crd),
        .pix       (pix)
    );

endmodule
